FILE: rtl/core/spmq_pkg.sv
// ----------------------------------------------------------------------------
// spmq_pkg
// Shared types and sizing for the strict-priority multi-queue.
// ----------------------------------------------------------------------------
package spmq_pkg;

  localparam int NUM_LEVELS  = 8;
  localparam int LEVEL_DEPTH = 16;

  localparam int LVL_W  = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int PTR_W  = $clog2(LEVEL_DEPTH);
  localparam int CNT_W  = $clog2(LEVEL_DEPTH + 1);
  localparam int SLOTS  = NUM_LEVELS * LEVEL_DEPTH;
  localparam int ADDR_W = $clog2(SLOTS);
  localparam int TOT_W  = $clog2(SLOTS + 1);

  localparam int HANDLE_W = 32;

  typedef enum logic [1:0] {
    CMD_ENQ  = 2'd0,
    CMD_DEQ  = 2'd1,
    CMD_TERM = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    STAT_OK    = 3'd0,
    STAT_EMPTY = 3'd1,
    STAT_FULL  = 3'd2,
    STAT_TERM  = 3'd3,
    STAT_NULL  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ
  } state_e;

  typedef struct packed {
    cmd_e                  cmd;
    logic [2:0]            priority_req;
    logic [HANDLE_W-1:0]   packet_handle;
  } req_t;

  typedef struct packed {
    status_e               status;
    logic [HANDLE_W-1:0]   out_handle;
    logic [2:0]            out_priority;
    logic [7:0]            total_count;
  } res_t;

endpackage

FILE: rtl/core/spmq_ram.sv
// ----------------------------------------------------------------------------
// spmq_ram
// Generic single-port RAM with a registered read.
// ----------------------------------------------------------------------------
module spmq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/strict_priority_multi_queue_unit.sv
// ----------------------------------------------------------------------------
// strict_priority_multi_queue_unit
// One FIFO of packet handles per priority level, strict-priority dequeue.
// ----------------------------------------------------------------------------
// A command is taken at a clock edge with start high and busy low. Exactly one
// result beat follows per command: done_o is high for one cycle with res_o
// valid, and the receiver cannot stall it, so it must capture the beat then.
// Enqueue, terminate, no-op and every refused or empty/terminated dequeue
// go from the execute state straight back to idle; a successful dequeue
// adds the read state for the registered read of the slot RAM. The result beat
// shows in the first cycle with busy low again, and a new command may be taken
// in that same cycle. Handles live in one single-port RAM of
// NUM_LEVELS*LEVEL_DEPTH words; per-level head/tail pointers and fill counts
// sit in flops and are cleared by reset, so no clearing pass is needed.
// Level 0 is most urgent. Terminate blocks dequeues only; enqueues keep
// working afterwards.
// ----------------------------------------------------------------------------
module strict_priority_multi_queue_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  spmq_pkg::req_t req_i,
  output logic          done_o,
  output spmq_pkg::res_t res_o
);
  import spmq_pkg::*;

  state_e state_q, state_d;

  // Command captured at accept.
  req_t req_q;

  // Per-level FIFO bookkeeping.
  logic [PTR_W-1:0] head_q [NUM_LEVELS];
  logic [PTR_W-1:0] tail_q [NUM_LEVELS];
  logic [CNT_W-1:0] cnt_q  [NUM_LEVELS];
  logic             stopped_q;
  logic [TOT_W-1:0] total_q, total_d;

  logic [LVL_W-1:0] deq_lvl_q;
  logic             done_q;
  res_t             res_q, res_d;

  // Decode of the captured command.
  logic [LVL_W-1:0] enq_lvl;
  logic             enq_in_range;
  logic [LVL_W-1:0] sel_lvl;
  logic             sel_found;

  logic             do_enq, do_deq, do_term, res_load;

  // Slot RAM port.
  logic              ram_en, ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [HANDLE_W-1:0] ram_rdata;

  assign enq_lvl      = LVL_W'(req_q.priority_req);
  assign enq_in_range = (int'(req_q.priority_req) < NUM_LEVELS);

  // Priority encoder over the non-empty flags, lowest level wins.
  always_comb begin
    sel_found = 1'b0;
    sel_lvl   = '0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (cnt_q[i] != '0) begin
        sel_found = 1'b1;
        sel_lvl   = LVL_W'(i);
      end
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start) state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = do_deq ? S_READ : S_IDLE;
      end
      S_READ: begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs of the sequencer: RAM access, bookkeeping strobes, result.
  always_comb begin
    do_enq   = 1'b0;
    do_deq   = 1'b0;
    do_term  = 1'b0;
    res_load = 1'b0;
    ram_en   = 1'b0;
    ram_we   = 1'b0;
    ram_addr = '0;
    res_d    = '{status: STAT_OK, out_handle: '0, out_priority: '0, total_count: '0};
    case (state_q)
      S_EXEC: begin
        case (req_q.cmd)
          CMD_ENQ: begin
            res_load = 1'b1;
            if (req_q.packet_handle == '0) begin
              res_d.status = STAT_NULL;
            end else if (!enq_in_range || (int'(cnt_q[enq_lvl]) >= LEVEL_DEPTH)) begin
              res_d.status = STAT_FULL;
            end else begin
              do_enq   = 1'b1;
              ram_en   = 1'b1;
              ram_we   = 1'b1;
              ram_addr = ADDR_W'(int'(enq_lvl) * LEVEL_DEPTH + int'(tail_q[enq_lvl]));
            end
          end
          CMD_DEQ: begin
            if (stopped_q) begin
              res_load     = 1'b1;
              res_d.status = STAT_TERM;
            end else if (!sel_found) begin
              res_load     = 1'b1;
              res_d.status = STAT_EMPTY;
            end else begin
              // Pop now; the handle comes back from the RAM next cycle.
              do_deq   = 1'b1;
              ram_en   = 1'b1;
              ram_addr = ADDR_W'(int'(sel_lvl) * LEVEL_DEPTH + int'(head_q[sel_lvl]));
            end
          end
          CMD_TERM: begin
            do_term  = 1'b1;
            res_load = 1'b1;
          end
          default: begin
            res_load = 1'b1;
          end
        endcase
      end
      S_READ: begin
        res_load           = 1'b1;
        res_d.out_handle   = ram_rdata;
        res_d.out_priority = 3'(deq_lvl_q);
      end
      default: ;
    endcase
    // Count after this step; pops were already applied before S_READ.
    res_d.total_count = (int'(total_d) > 255) ? 8'hFF : 8'(total_d);
  end

  always_comb begin
    total_d = total_q;
    if (do_enq) total_d = total_q + TOT_W'(1);
    if (do_deq) total_d = total_q - TOT_W'(1);
  end

  spmq_ram #(
    .WIDTH(HANDLE_W),
    .DEPTH(SLOTS)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .en_i   (ram_en),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(req_q.packet_handle),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      stopped_q <= 1'b0;
      total_q   <= '0;
      done_q    <= 1'b0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
    end else begin
      state_q <= state_d;
      total_q <= total_d;
      done_q  <= res_load;
      if (do_term) stopped_q <= 1'b1;
      if (do_enq) begin
        tail_q[enq_lvl] <= (int'(tail_q[enq_lvl]) == LEVEL_DEPTH - 1) ? '0
                           : tail_q[enq_lvl] + PTR_W'(1);
        cnt_q[enq_lvl]  <= cnt_q[enq_lvl] + CNT_W'(1);
      end
      if (do_deq) begin
        head_q[sel_lvl] <= (int'(head_q[sel_lvl]) == LEVEL_DEPTH - 1) ? '0
                           : head_q[sel_lvl] + PTR_W'(1);
        cnt_q[sel_lvl]  <= cnt_q[sel_lvl] - CNT_W'(1);
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (start && !busy) req_q <= req_i;
    if (do_deq)         deq_lvl_q <= sel_lvl;
    if (res_load)       res_q <= res_d;
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

FILE: rtl/core/spmq_chk.sv
// ----------------------------------------------------------------------------
// spmq_chk
// Port-level checks for the strict-priority multi-queue, bound to the top.
// ----------------------------------------------------------------------------
module spmq_chk (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input logic           done_o,
  input spmq_pkg::res_t res_o
);
  import spmq_pkg::*;

  // An accepted command keeps the unit busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted command did not raise busy");

  // A result beat only follows a cycle of work.
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result beat without preceding work");

  // One beat per command; beats never come back to back.
  a_single_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("back-to-back result beats");

  // Anything but a good beat returns no handle.
  a_no_handle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (res_o.status != STAT_OK) |-> (res_o.out_handle == '0))
    else $error("handle returned with non-ok status");

  // Empty means nothing is held anywhere.
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (res_o.status == STAT_EMPTY) |-> (res_o.total_count == '0))
    else $error("empty reported with handles held");

endmodule

bind strict_priority_multi_queue_unit spmq_chk u_spmq_chk (
  .clk_i (clk_i),
  .rst_ni(rst_ni),
  .start (start),
  .busy  (busy),
  .done_o(done_o),
  .res_o (res_o)
);

FILE: verif/tb_strict_priority_multi_queue_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_strict_priority_multi_queue_unit
// Self-checking bench for the strict-priority multi-queue of packet handles.
// Commands go in through start/busy. A local queue model predicts each result
// beat, and every done_o beat is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_strict_priority_multi_queue_unit;
  import spmq_pkg::*;

  localparam int CLK_HALF    = 2;
  localparam int CYCLE_LIMIT = 100000;
  localparam int DRAIN_WAIT  = 10;      // result beat follows the fall of busy
  localparam int MAX_REPORTS = 10;

  // Burst flavors for the random traffic
  typedef enum int {
    BURST_FILL,
    BURST_DRAIN,
    BURST_MIXED
  } burst_e;

  logic   clk_i;
  logic   rst_ni;
  logic   start;
  logic   busy;
  req_t   req_i;
  logic   done_o;
  res_t   res_o;

  // Queue model state: one ring buffer per level, plus the terminate flag
  logic [HANDLE_W-1:0] held_handles [NUM_LEVELS][LEVEL_DEPTH];
  int unsigned         rd_idx   [NUM_LEVELS];
  int unsigned         wr_idx   [NUM_LEVELS];
  int unsigned         fill_cnt [NUM_LEVELS];
  bit                  term_seen;

  res_t        pending_res[$];   // predicted result beats, oldest first
  res_t        exp_res;
  int unsigned idle_pct;         // sender gap chance per beat, in percent
  int unsigned cmds_sent;
  int unsigned results_checked;
  int unsigned err_cnt;
  int unsigned cycle_cnt;
  int unsigned status_tally [5];

  strict_priority_multi_queue_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .res_o  (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake ends the run here
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("watchdog expired after %0d cycles", cycle_cnt);
      $display("strict_priority_multi_queue_unit: mismatch");
      $finish;
    end
  end

  function automatic void note_failure(input string msg);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS)
      $display("[%0t] ERROR: %s", $realtime, msg);
  endfunction

  // Applies one command to the queue model and returns the beat it causes.
  function automatic res_t queue_model_step(input req_t rq);
    res_t        r;
    int unsigned lvl;
    int unsigned lv;
    int unsigned sum;
    r        = '0;
    r.status = STAT_OK;
    lvl      = rq.priority_req;
    lv       = 0;
    sum      = 0;
    case (rq.cmd)
      CMD_ENQ: begin
        // Null check wins over the fullness check
        if (rq.packet_handle == '0) begin
          r.status = STAT_NULL;
        end else if (lvl >= NUM_LEVELS || fill_cnt[lvl] >= LEVEL_DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          held_handles[lvl][wr_idx[lvl]] = rq.packet_handle;
          wr_idx[lvl] = (wr_idx[lvl] + 1 >= LEVEL_DEPTH) ? 0 : wr_idx[lvl] + 1;
          fill_cnt[lvl]++;
        end
      end
      CMD_DEQ: begin
        if (term_seen) begin
          r.status = STAT_TERM;
        end else begin
          while (lv < NUM_LEVELS && fill_cnt[lv] == 0)
            lv++;
          if (lv >= NUM_LEVELS) begin
            r.status = STAT_EMPTY;
          end else begin
            r.out_handle   = held_handles[lv][rd_idx[lv]];
            r.out_priority = lv[2:0];
            rd_idx[lv] = (rd_idx[lv] + 1 >= LEVEL_DEPTH) ? 0 : rd_idx[lv] + 1;
            fill_cnt[lv]--;
          end
        end
      end
      CMD_TERM: begin
        term_seen = 1'b1;
      end
      default: begin
      end
    endcase
    for (int i = 0; i < NUM_LEVELS; i++)
      sum += fill_cnt[i];
    r.total_count = (sum > 255) ? 8'd255 : sum[7:0];
    return r;
  endfunction

  function automatic req_t mk_req(input cmd_e c, input int unsigned lvl,
                                  input logic [HANDLE_W-1:0] h);
    req_t rq;
    rq.cmd           = c;
    rq.priority_req  = lvl[2:0];
    rq.packet_handle = h;
    return rq;
  endfunction

  // One random command shaped by the burst flavor. Fill bursts lean on one
  // level so it reaches full; drain bursts pull levels down to empty.
  function automatic req_t random_req(input burst_e kind, input int unsigned focus,
                                      input bit allow_term);
    req_t        rq;
    int unsigned roll;
    roll             = $urandom_range(0, 99);
    rq.priority_req  = ($urandom_range(0, 3) != 0) ? focus[2:0] : 3'($urandom_range(0, 7));
    rq.packet_handle = $urandom;
    if ($urandom_range(0, 24) == 0)
      rq.packet_handle = '0;
    case (kind)
      BURST_FILL:  rq.cmd = (roll < 88) ? CMD_ENQ : (roll < 96) ? CMD_DEQ : CMD_NOP;
      BURST_DRAIN: rq.cmd = (roll < 88) ? CMD_DEQ : (roll < 96) ? CMD_ENQ : CMD_NOP;
      default:     rq.cmd = (roll < 48) ? CMD_ENQ : (roll < 92) ? CMD_DEQ : CMD_NOP;
    endcase
    if (allow_term && roll >= 97)
      rq.cmd = CMD_TERM;
    return rq;
  endfunction

  // Drives one command and holds it until the block takes it. Called just
  // after a rising edge; busy read there is the value the block sampled.
  task automatic send_item(input req_t rq);
    start <= 1'b1;
    req_i <= rq;
    @(posedge clk_i);
    while (busy)
      @(posedge clk_i);
    pending_res.push_back(queue_model_step(rq));
    cmds_sent++;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic run_bursts(input int unsigned n_items, input bit allow_term);
    int unsigned sent;
    int unsigned burst_len;
    int unsigned focus;
    int unsigned pick;
    burst_e      kind;
    sent = 0;
    while (sent < n_items) begin
      pick      = $urandom_range(0, 9);
      kind      = (pick < 4) ? BURST_FILL : (pick < 7) ? BURST_DRAIN : BURST_MIXED;
      burst_len = (kind == BURST_DRAIN) ? $urandom_range(1, 48) : $urandom_range(1, 24);
      focus     = $urandom_range(0, NUM_LEVELS - 1);
      for (int k = 0; k < burst_len && sent < n_items; k++) begin
        send_item(random_req(kind, focus, allow_term));
        sent++;
      end
    end
  endtask

  // Fresh block: dequeue on empty, the spare command code, a null handle
  task automatic test_empty_and_noop();
    send_item(mk_req(CMD_DEQ, 0, '0));
    send_item(mk_req(CMD_NOP, 7, 32'hFFFF_FFFF));
    send_item(mk_req(CMD_ENQ, 5, '0));
  endtask

  // Fill the lowest-urgency level to depth, then one more is refused
  task automatic test_level_full();
    logic [HANDLE_W-1:0] h;
    for (int i = 0; i <= LEVEL_DEPTH; i++) begin
      case (i)
        0:       h = 32'hFFFF_FFFF;
        1:       h = 32'h0000_0001;
        2:       h = 32'h8000_0000;
        default: h = (i % 2 != 0) ? (32'hAAAA_AAAA ^ i) : (32'h5555_5555 ^ i);
      endcase
      send_item(mk_req(CMD_ENQ, NUM_LEVELS - 1, h));
    end
  endtask

  // Level 0 jumps ahead of the full level 7, then level 7 pops its oldest
  task automatic test_strict_priority();
    send_item(mk_req(CMD_ENQ, 0, 32'h0000_0001));
    send_item(mk_req(CMD_DEQ, 0, '0));
    send_item(mk_req(CMD_DEQ, 3, '0));
  endtask

  task automatic test_random_traffic(input int unsigned n_items, input int unsigned pct);
    idle_pct = pct;
    run_bursts(n_items, 1'b0);
  endtask

  // Terminate is sticky and reset happens once, so this runs last
  task automatic test_terminate();
    idle_pct = 19;
    send_item(mk_req(CMD_ENQ, 2, 32'hDEAD_BEEF));
    send_item(mk_req(CMD_TERM, 0, '0));
    send_item(mk_req(CMD_DEQ, 0, '0));         // handles queued, still refused
    send_item(mk_req(CMD_ENQ, 4, 32'h1234_5678));
    send_item(mk_req(CMD_TERM, 6, 32'hFFFF_FFFF));
    send_item(mk_req(CMD_DEQ, 0, '0));
    run_bursts(40, 1'b1);
  endtask

  // Result side: one beat per done_o, no back-pressure possible
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_res.size() == 0) begin
        note_failure($sformatf("result beat with nothing predicted: %p", res_o));
      end else begin
        exp_res = pending_res.pop_front();
        results_checked++;
        if (res_o.status !== exp_res.status || res_o.out_handle !== exp_res.out_handle ||
            res_o.out_priority !== exp_res.out_priority ||
            res_o.total_count !== exp_res.total_count) begin
          note_failure($sformatf(
            "beat %0d exp st=%0d h=%h lvl=%0d cnt=%0d got st=%0d h=%h lvl=%0d cnt=%0d",
            results_checked, exp_res.status, exp_res.out_handle, exp_res.out_priority,
            exp_res.total_count, res_o.status, res_o.out_handle, res_o.out_priority,
            res_o.total_count));
        end
        status_tally[exp_res.status]++;
      end
    end
  end

  initial begin
    rst_ni    = 1'b0;
    start     = 1'b0;
    req_i     = '0;
    idle_pct  = 0;
    cycle_cnt = 0;
    term_seen = 1'b0;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      rd_idx[i]   = 0;
      wr_idx[i]   = 0;
      fill_cnt[i] = 0;
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_and_noop();
    test_level_full();
    test_strict_priority();
    test_random_traffic(290, 0);    // back to back
    test_random_traffic(290, 87);   // sparse sender
    test_random_traffic(230, 19);   // light gaps
    test_terminate();

    start <= 1'b0;
    while (pending_res.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (pending_res.size() != 0)
      note_failure($sformatf("%0d predicted beats never arrived", pending_res.size()));

    $display("covered %0d commands (directed, back-to-back, gapped, post-terminate); %0d beats checked",
             cmds_sent, results_checked);
    $display("beat status mix: ok %0d, empty %0d, full %0d, terminated %0d, null %0d; errors %0d",
             status_tally[STAT_OK], status_tally[STAT_EMPTY], status_tally[STAT_FULL],
             status_tally[STAT_TERM], status_tally[STAT_NULL], err_cnt);
    if (err_cnt == 0) begin
      $display("strict_priority_multi_queue_unit: match");
    end else begin
      $display("strict_priority_multi_queue_unit: mismatch");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/spmq_pkg.sv
rtl/core/spmq_ram.sv
rtl/core/strict_priority_multi_queue_unit.sv
rtl/core/spmq_chk.sv
verif/tb_strict_priority_multi_queue_unit.sv
